[src/line_sensor_pid_steering_assert.svh]
// Assertion macros used by the top RTL file of the line-sensor steering block.
`ifndef LINE_SENSOR_PID_STEERING_ASSERT_SVH
`define LINE_SENSOR_PID_STEERING_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define LSPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line_sensor_pid_steering: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define LSPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line_sensor_pid_steering: next-cycle check failed");

`endif

[src/lsps_pkg.sv]
package lsps_pkg;

    // Field widths
    localparam int SENSOR_COUNT = 8;
    localparam int BYTE_W       = 8;
    localparam int ERR_W        = 5;
    localparam int DIFF_W       = 6;
    localparam int SUM_W        = 18;
    localparam int GAIN_W       = 10;
    localparam int TURN_W       = 16;
    localparam int SPEED_W      = 17;
    localparam int COUNT_W      = 4;
    localparam int CFG_IDX_W    = 8;

    // Saturation limits
    localparam int SUM_LIMIT = 65535;
    localparam int TURN_MAX  = 32767;
    localparam int TURN_MIN  = -32768;
    localparam int SHARP_ERR = 15;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 8'd3;

    // Register reset values
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 10'd500;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 10'd0;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 10'd0;
    localparam logic [GAIN_W-1:0] BASE_SPEED_RST = 10'd300;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain;
        logic [GAIN_W-1:0] deriv_gain;
        logic [GAIN_W-1:0] base_speed;
    } t_gains;

    typedef struct packed {
        logic signed [ERR_W-1:0] position_error;
        logic                    sharp_turn;
        logic [BYTE_W-1:0]       black_mask;
        logic [COUNT_W-1:0]      black_count;
    } t_decode;

    // Pattern list, first match wins; later repeats of a pattern never match
    // and are left out.
    function automatic logic signed [ERR_W-1:0] match_pattern(input logic [BYTE_W-1:0] b);
        logic signed [ERR_W-1:0] e;
        case (b)
            8'h07:   e = -5'sd15;
            8'hE0:   e = 5'sd15;
            8'h0F:   e = -5'sd14;
            8'hF0:   e = 5'sd14;
            8'h7F:   e = -5'sd13;
            8'hFE:   e = 5'sd13;
            8'h3F:   e = -5'sd12;
            8'hFC:   e = 5'sd12;
            8'h1F:   e = -5'sd11;
            8'hF8:   e = 5'sd11;
            8'h87:   e = -5'sd9;
            8'hE1:   e = 5'sd9;
            8'hC3:   e = -5'sd8;
            8'h8F:   e = -5'sd7;
            8'hF1:   e = 5'sd7;
            8'hDF:   e = -5'sd6;
            8'hFB:   e = 5'sd6;
            8'hBF:   e = -5'sd5;
            8'hFD:   e = 5'sd5;
            8'h9F:   e = -5'sd4;
            8'hF9:   e = 5'sd4;
            8'h83:   e = -5'sd1;
            8'hC1:   e = 5'sd1;
            default: e = 5'sd0;
        endcase
        return e;
    endfunction

endpackage

[src/line_sensor_pid_steering.sv]
// Line-sensor PID steering: each 8-bit sensor byte (bit 7 is sensor 1, 0 is
// black) is matched against a fixed pattern list to give a position error of
// -15..15, which drives an integer PID step (error sum clamped to +/-65535,
// turn clamped to 16 bits) and the left/right wheel commands base +/- turn.
// The block takes one item per clock when no stall holds it; the item passes
// through one input register, then the pattern lookup, sum update, three
// 10-bit gain multiplies and clamps in a single pass into the result
// register. A stall on the output backs up through both registers. Gain
// registers are written through the config port, which is always ready;
// write them only while no item is in flight.
`include "line_sensor_pid_steering_assert.svh"

module line_sensor_pid_steering (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Sensor items in
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [lsps_pkg::BYTE_W-1:0]            i_sensor_byte,
    // Steering items out
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [lsps_pkg::ERR_W-1:0]      o_position_error,
    output logic signed [lsps_pkg::TURN_W-1:0]     o_turn_value,
    output logic signed [lsps_pkg::SPEED_W-1:0]    o_left_wheel,
    output logic signed [lsps_pkg::SPEED_W-1:0]    o_right_wheel,
    output logic                                   o_sharp_turn,
    output logic [lsps_pkg::BYTE_W-1:0]            o_black_mask,
    output logic [lsps_pkg::COUNT_W-1:0]           o_black_count,
    // Register writes
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [lsps_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [lsps_pkg::GAIN_W-1:0]            i_cfg_data
);

    logic                                r_in_valid;
    logic [lsps_pkg::BYTE_W-1:0]         r_in_byte;
    logic                                r_out_valid;
    logic signed [lsps_pkg::ERR_W-1:0]   r_position_error;
    logic signed [lsps_pkg::TURN_W-1:0]  r_turn_value;
    logic signed [lsps_pkg::SPEED_W-1:0] r_left_wheel;
    logic signed [lsps_pkg::SPEED_W-1:0] r_right_wheel;
    logic                                r_sharp_turn;
    logic [lsps_pkg::BYTE_W-1:0]         r_black_mask;
    logic [lsps_pkg::COUNT_W-1:0]        r_black_count;
    lsps_pkg::t_gains                    r_gains;

    logic                                advance;
    lsps_pkg::t_decode                   decode;
    logic signed [lsps_pkg::TURN_W-1:0]  turn;
    logic signed [lsps_pkg::SPEED_W-1:0] left_wheel;
    logic signed [lsps_pkg::SPEED_W-1:0] right_wheel;

    // Move the held item forward when the result register is free or drains
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign o_cfg_ready = 1'b1;

    // Capture sensor items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_sensor_byte;
        end
    end

    // Write gain and speed registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.prop_gain  <= lsps_pkg::PROP_GAIN_RST;
            r_gains.integ_gain <= lsps_pkg::INTEG_GAIN_RST;
            r_gains.deriv_gain <= lsps_pkg::DERIV_GAIN_RST;
            r_gains.base_speed <= lsps_pkg::BASE_SPEED_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                lsps_pkg::REG_PROP_GAIN:  r_gains.prop_gain  <= i_cfg_data;
                lsps_pkg::REG_INTEG_GAIN: r_gains.integ_gain <= i_cfg_data;
                lsps_pkg::REG_DERIV_GAIN: r_gains.deriv_gain <= i_cfg_data;
                lsps_pkg::REG_BASE_SPEED: r_gains.base_speed <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lsps_decode u_decode (
        .i_sensor_byte (r_in_byte),
        .o_decode      (decode)
    );

    lsps_pid u_pid (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_err     (decode.position_error),
        .i_gains   (r_gains),
        .o_turn    (turn),
        .o_left    (left_wheel),
        .o_right   (right_wheel)
    );

    // Load results; drop valid once the item is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_position_error <= decode.position_error;
            r_turn_value     <= turn;
            r_left_wheel     <= left_wheel;
            r_right_wheel    <= right_wheel;
            r_sharp_turn     <= decode.sharp_turn;
            r_black_mask     <= decode.black_mask;
            r_black_count    <= decode.black_count;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_position_error = r_position_error;
    assign o_turn_value     = r_turn_value;
    assign o_left_wheel     = r_left_wheel;
    assign o_right_wheel    = r_right_wheel;
    assign o_sharp_turn     = r_sharp_turn;
    assign o_black_mask     = r_black_mask;
    assign o_black_count    = r_black_count;

    `LSPS_ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_in_valid)
    `LSPS_ASSERT_SAME(a_sharp_is_edge, i_clk, i_rst_n, o_out_valid && o_sharp_turn,
        (o_position_error == 5'sd15) || (o_position_error == -5'sd15))
    `LSPS_ASSERT_SAME(a_wheel_spread, i_clk, i_rst_n, o_out_valid,
        (18'(o_left_wheel) - 18'(o_right_wheel)) == (18'(o_turn_value) <<< 1))
    `LSPS_ASSERT_SAME(a_count_mask, i_clk, i_rst_n, o_out_valid,
        $countones(o_black_mask) == int'(o_black_count))

endmodule

[src/lsps_decode.sv]
module lsps_decode (
    input  logic [lsps_pkg::BYTE_W-1:0] i_sensor_byte,
    output lsps_pkg::t_decode           o_decode
);

    localparam int CW = lsps_pkg::COUNT_W;

    logic signed [lsps_pkg::ERR_W-1:0] err;
    logic [lsps_pkg::BYTE_W-1:0]       mask;
    logic [CW-1:0]                     count;

    // Look up the position error
    assign err = lsps_pkg::match_pattern(i_sensor_byte);

    // Invert and reverse the byte so bit i is sensor i+1, then count blacks
    always_comb begin
        mask  = '0;
        count = '0;
        for (int i = 0; i < lsps_pkg::SENSOR_COUNT; i++) begin
            mask[i] = ~i_sensor_byte[lsps_pkg::SENSOR_COUNT-1-i];
            count   = count + CW'(mask[i]);
        end
    end

    // Pack the decode result
    always_comb begin
        o_decode.position_error = err;
        o_decode.sharp_turn     = (err == 5'(lsps_pkg::SHARP_ERR))
                               || (err == 5'(-lsps_pkg::SHARP_ERR));
        o_decode.black_mask     = mask;
        o_decode.black_count    = count;
    end

endmodule

[src/lsps_pid.sv]
module lsps_pid (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_advance,
    input  logic signed [lsps_pkg::ERR_W-1:0]     i_err,
    input  lsps_pkg::t_gains                      i_gains,
    output logic signed [lsps_pkg::TURN_W-1:0]    o_turn,
    output logic signed [lsps_pkg::SPEED_W-1:0]   o_left,
    output logic signed [lsps_pkg::SPEED_W-1:0]   o_right
);

    localparam int SW  = lsps_pkg::SUM_W;
    localparam int DW  = lsps_pkg::DIFF_W;
    localparam int GW  = lsps_pkg::GAIN_W;
    localparam int TW  = lsps_pkg::TURN_W;
    localparam int VW  = lsps_pkg::SPEED_W;
    localparam int ACW = GW + 1 + SW + 1;

    logic signed [SW-1:0]                 r_sum, n_sum;
    logic signed [lsps_pkg::ERR_W-1:0]    r_prev;
    logic signed [SW:0]                   sum_wide;
    logic signed [DW-1:0]                 diff;
    logic signed [GW:0]                   prop_s, integ_s, deriv_s;
    logic signed [ACW-1:0]                p_term, i_term, d_term, acc;
    logic signed [GW:0]                   base_s;

    // Add the new error to the running sum and clamp it
    always_comb begin
        sum_wide = (SW+1)'(r_sum) + (SW+1)'(i_err);
        if (sum_wide > (SW+1)'(lsps_pkg::SUM_LIMIT)) begin
            n_sum = SW'(lsps_pkg::SUM_LIMIT);
        end else if (sum_wide < (SW+1)'(-lsps_pkg::SUM_LIMIT)) begin
            n_sum = SW'(-lsps_pkg::SUM_LIMIT);
        end else begin
            n_sum = SW'(sum_wide);
        end
    end

    // Form the three gain products and their sum
    always_comb begin
        prop_s  = $signed({1'b0, i_gains.prop_gain});
        integ_s = $signed({1'b0, i_gains.integ_gain});
        deriv_s = $signed({1'b0, i_gains.deriv_gain});
        diff    = DW'(i_err) - DW'(r_prev);
        p_term  = ACW'(prop_s) * ACW'(i_err);
        i_term  = ACW'(integ_s) * ACW'(n_sum);
        d_term  = ACW'(deriv_s) * ACW'(diff);
        acc     = p_term + i_term + d_term;
    end

    // Clamp the turn and steer the wheels around the base speed
    always_comb begin
        if (acc > ACW'(lsps_pkg::TURN_MAX)) begin
            o_turn = TW'(lsps_pkg::TURN_MAX);
        end else if (acc < ACW'(lsps_pkg::TURN_MIN)) begin
            o_turn = TW'(lsps_pkg::TURN_MIN);
        end else begin
            o_turn = TW'(acc);
        end
        base_s  = $signed({1'b0, i_gains.base_speed});
        o_left  = VW'(base_s) + VW'(o_turn);
        o_right = VW'(base_s) - VW'(o_turn);
    end

    // Advance the PID state once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_prev <= '0;
        end else if (i_advance) begin
            r_sum  <= n_sum;
            r_prev <= i_err;
        end
    end

endmodule
